// ===== src/tps_pkg.sv =====
package tps_pkg;

	localparam int NUM_TASKS    = 8;
	localparam int TASK_W       = $clog2(NUM_TASKS);
	localparam int CNT_W        = 4;
	localparam int PRIO_W       = 32;
	localparam int PRIO_FIELDS  = PRIO_W / CNT_W;
	localparam int OUT_TASK_W   = 3;

	typedef struct packed {
		logic load;
		logic dec;
		logic scan_init;
		logic scan_step;
		logic refill;
		logic commit;
	} tps_cmd_t;

	typedef struct packed {
		logic need_sched;
		logic scan_last;
		logic best_zero;
		logic refilled;
		logic out_free;
	} tps_sts_t;

	function automatic logic [CNT_W-1:0] prio_of(input logic [PRIO_W-1:0] tbl,
		input logic [TASK_W-1:0] idx);
		logic [CNT_W-1:0] res;
		res = '0;
		if (idx != '0 && int'(idx) < PRIO_FIELDS) begin
			res = tbl[int'(idx) * CNT_W +: CNT_W];
		end
		return res;
	endfunction

endpackage

// ===== src/tps_ctrl.sv =====
module tps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              timer_tick,
	output logic              in_stall,
	input  tps_pkg::tps_sts_t sts,
	output tps_pkg::tps_cmd_t cmd
);
	import tps_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_CHECK  = 6'b001000,
		ST_REFILL = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = timer_tick ? ST_DECIDE : ST_DONE;
				end
			end
			ST_DECIDE: begin
				cmd.dec = 1'b1;
				if (sts.need_sched) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (sts.best_zero && !sts.refilled) ? ST_REFILL : ST_DONE;
			end
			ST_REFILL: begin
				cmd.refill    = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/tps_dpath.sv =====
module tps_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tps_pkg::PRIO_W-1:0]      cfg_wdata,
	input  tps_pkg::tps_cmd_t               cmd,
	output tps_pkg::tps_sts_t               sts,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tps_pkg::OUT_TASK_W-1:0]  running_task,
	output logic                            switched,
	output logic [tps_pkg::CNT_W-1:0]       running_count,
	output logic                            refilled
);
	import tps_pkg::*;

	logic [PRIO_W-1:0]     prio_q;
	logic [CNT_W-1:0]      cnt_q [NUM_TASKS];
	logic [TASK_W-1:0]     running_q;
	logic [TASK_W-1:0]     idx_q;
	logic [TASK_W-1:0]     best_q;
	logic [CNT_W-1:0]      best_cnt_q;
	logic                  sched_q;
	logic                  refilled_q;
	logic                  scanning_q;
	logic                  out_valid_q;
	logic [OUT_TASK_W-1:0] out_task_q;
	logic                  out_sw_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  out_rf_q;

	logic [TASK_W-1:0] target;
	logic [TASK_W-1:0] raddr;
	logic [CNT_W-1:0]  rdata;
	logic              cur_idle;

	assign target   = sched_q ? best_q : running_q;
	assign raddr    = scanning_q ? idx_q : target;
	assign rdata    = cnt_q[raddr];
	assign cur_idle = (running_q == '0);

	assign sts.need_sched = cur_idle || (rdata <= CNT_W'(1));
	assign sts.scan_last  = (idx_q == TASK_W'(NUM_TASKS - 1));
	assign sts.best_zero  = (best_q == '0);
	assign sts.refilled   = refilled_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= '0;
		end else if (cfg_we) begin
			prio_q <= cfg_wdata;
		end
	end

	// slice counters, task 0 never written non-zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.refill) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				cnt_q[i] <= prio_of(prio_q, TASK_W'(i));
			end
		end else if (cmd.dec && !cur_idle && rdata != '0) begin
			cnt_q[running_q] <= rdata - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= '0;
			sched_q    <= 1'b0;
			refilled_q <= 1'b0;
			scanning_q <= 1'b0;
			idx_q      <= '0;
			best_q     <= '0;
			best_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				sched_q    <= 1'b0;
				refilled_q <= 1'b0;
			end
			if (cmd.dec && sts.need_sched) begin
				sched_q <= 1'b1;
			end
			if (cmd.refill) begin
				refilled_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				scanning_q <= 1'b1;
				idx_q      <= TASK_W'(1);
				best_q     <= '0;
				best_cnt_q <= '0;
			end else if (cmd.scan_step) begin
				// strict compare keeps the lowest index on ties
				if (rdata > best_cnt_q) begin
					best_q     <= idx_q;
					best_cnt_q <= rdata;
				end
				if (sts.scan_last) begin
					scanning_q <= 1'b0;
				end else begin
					idx_q <= idx_q + TASK_W'(1);
				end
			end
			if (cmd.commit) begin
				running_q <= target;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_task_q <= OUT_TASK_W'(target);
			out_sw_q   <= (target != running_q);
			out_cnt_q  <= rdata;
			out_rf_q   <= refilled_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign running_task  = out_task_q;
	assign switched      = out_sw_q;
	assign running_count = out_cnt_q;
	assign refilled      = out_rf_q;

endmodule

// ===== src/timeslice_priority_scheduler.sv =====
// timeslice priority scheduler
//
// input channel (in_valid / in_stall, timer_tick): one request per tick or
// status query. a tick decrements the running task's slice and, when the
// slice runs out or idle is running, picks the task with the largest
// remaining slice (lowest index on ties), reloading all slices from
// priority_table when every slice is empty.
// output channel (out_valid / out_stall): one result per request with the
// running task, its remaining slice, and the switched and refilled flags.
// cfg_we / cfg_wdata write the priority table at any edge; the user is to write it only
// while idle, which the block itself does not enforce. a status query goes straight to
// the result; a tick first decrements in a decide step, and a rescheduling tick then scans
// the slice counters, reading one slice counter per cycle, and scans again after a refill.
// one request is in flight at a time; in_stall is high while it is worked.
// a finished result waits in the output register while out_stall is high,
// and the next request can be taken meanwhile but is held at its end.
// reset clears all slices, selects idle and zeroes the priority table.
module timeslice_priority_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tps_pkg::PRIO_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            timer_tick,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tps_pkg::OUT_TASK_W-1:0]  running_task,
	output logic                            switched,
	output logic [tps_pkg::CNT_W-1:0]       running_count,
	output logic                            refilled
);
	import tps_pkg::*;

	tps_cmd_t cmd;
	tps_sts_t sts;

	tps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.timer_tick (timer_tick),
		.in_stall   (in_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	tps_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.running_task  (running_task),
		.switched      (switched),
		.running_count (running_count),
		.refilled      (refilled)
	);

endmodule

// ===== src/tps_checker.sv =====
module tps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [tps_pkg::OUT_TASK_W-1:0]  running_task,
	input logic                            switched,
	input logic [tps_pkg::CNT_W-1:0]       running_count,
	input logic                            refilled
);
	import tps_pkg::*;

	// idle always reports an empty slice
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running_task == '0 |-> running_count == '0)
		else $error("idle task reported with non-zero slice");

	// a real task is never left running on an empty slice
	a_task_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running_task != '0 |-> running_count != '0)
		else $error("task running with empty slice");

	// idle is only entered through an empty refill
	a_idle_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched && running_task == '0 |-> refilled)
		else $error("switch to idle without a refill");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(running_task)
			&& $stable(running_count) && $stable(switched) && $stable(refilled))
		else $error("stalled result changed");

endmodule

bind timeslice_priority_scheduler tps_checker u_tps_checker (.*);
